@@ rtl/vertex_project_viewport_unit_assert.svh @@
// Assertion macros for the projection unit RTL.
// Depends on nothing; pulled in by files that carry concurrent checks.
`ifndef VERTEX_PROJECT_VIEWPORT_UNIT_ASSERT_SVH
`define VERTEX_PROJECT_VIEWPORT_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define VPV_ASSERT_IMPLIES(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("vpv check failed");
// next-cycle implication
`define VPV_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("vpv check failed");
`else
`define VPV_ASSERT_IMPLIES(label, clk, rst_n, pre, post)
`define VPV_ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

@@ rtl/vpv_pkg.sv @@
// Package for the vertex projection unit: widths, codes, item types, saturation.
// No dependencies.
`default_nettype none

package vpv_pkg;

    localparam int MATRIX_SIZE     = 4;
    localparam int MAT_WORDS       = MATRIX_SIZE * MATRIX_SIZE;
    localparam int FRACTION_BITS   = 16;
    localparam int DATA_W          = 32;
    localparam int COEF_IDX_W      = $clog2(MAT_WORDS);
    localparam int SIZE_W          = 15;
    localparam int CFG_IDX_W       = 1;
    localparam int NUM_LANES       = 4;
    localparam int ONE_Q           = 1 << FRACTION_BITS;

    // product / row sum / clip widths
    localparam int PROD_W          = 2 * DATA_W;
    localparam int SUM_W           = PROD_W + 2;
    localparam int CLIP_W          = PROD_W + 1 - FRACTION_BITS;
    localparam int MAG_W           = CLIP_W;
    localparam int N_W             = MAG_W + FRACTION_BITS;

    // quotient magnitude clamps at 2^QUOT_LIMIT_EXP
    localparam int QUOT_LIMIT_EXP  = 47;
    localparam int QUOT_STEPS      = QUOT_LIMIT_EXP + 1;
    localparam int QV_W            = QUOT_STEPS + 1;
    localparam int VP_PROD_W       = QV_W + SIZE_W + 1;

    localparam int QUEUE_DEPTH     = 2;
    localparam int QPTR_W          = $clog2(QUEUE_DEPTH);

    localparam logic [SIZE_W-1:0] WIDTH_RESET  = SIZE_W'(640);
    localparam logic [SIZE_W-1:0] HEIGHT_RESET = SIZE_W'(480);

    typedef enum logic {
        OP_COEF    = 1'b0,
        OP_PROJECT = 1'b1
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH  = 1'b0,
        CFG_HEIGHT = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        t_op                      op;
        logic [COEF_IDX_W-1:0]    coef_index;
        logic signed [DATA_W-1:0] coef_value;
        logic signed [DATA_W-1:0] pos_x;
        logic signed [DATA_W-1:0] pos_y;
        logic signed [DATA_W-1:0] pos_z;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] screen_x;
        logic signed [DATA_W-1:0] screen_y;
        logic signed [DATA_W-1:0] depth_z;
        logic signed [DATA_W-1:0] recip_w;
        logic                     w_zero;
    } t_out_item;

    typedef struct packed {
        logic signed [CLIP_W-1:0] x;
        logic signed [CLIP_W-1:0] y;
        logic signed [CLIP_W-1:0] z;
        logic signed [CLIP_W-1:0] w;
    } t_clip;

    typedef struct packed {
        logic signed [QV_W-1:0] nx;
        logic signed [QV_W-1:0] ny;
        logic signed [QV_W-1:0] nz;
        logic signed [QV_W-1:0] rw;
        logic                   w_zero;
    } t_quot;

    // clamp a wide signed value to the 32-bit range
    function automatic logic signed [DATA_W-1:0] sat_data(
        input logic signed [VP_PROD_W-1:0] v
    );
        logic [VP_PROD_W-DATA_W:0] hi;
        hi = v[VP_PROD_W-1:DATA_W-1];
        if (hi == '0 || hi == '1) begin
            return v[DATA_W-1:0];
        end else if (v[VP_PROD_W-1]) begin
            return {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            return {1'b0, {(DATA_W-1){1'b1}}};
        end
    endfunction

endpackage

`default_nettype wire

@@ rtl/vpv_front.sv @@
// Front end: takes items, holds the matrix, forms clip coordinates.
// Depends on vpv_pkg.
`default_nettype none

module vpv_front import vpv_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    output logic   o_full,
    input  t_in_item i_item,
    output logic   o_valid,
    output t_clip  o_clip,
    input  logic   i_ready
);

    logic signed [DATA_W-1:0] r_mat  [MAT_WORDS];
    logic                     r_p_valid;
    logic signed [PROD_W-1:0] r_prod [MATRIX_SIZE][MATRIX_SIZE];
    logic                     r_s_valid;
    logic signed [PROD_W:0]   r_pair [MATRIX_SIZE][2];

    logic signed [PROD_W-1:0] n_prod [MATRIX_SIZE][MATRIX_SIZE];
    logic signed [PROD_W:0]   n_pair [MATRIX_SIZE][2];
    logic signed [SUM_W-1:0]  row_sum [MATRIX_SIZE];
    logic signed [DATA_W-1:0] pos [MATRIX_SIZE-1];
    logic fe_en;
    logic accept;

    assign fe_en  = !r_s_valid || i_ready;
    assign o_full = !fe_en;
    assign accept = i_push && fe_en;
    assign o_valid = r_s_valid;

    assign pos[0] = i_item.pos_x;
    assign pos[1] = i_item.pos_y;
    assign pos[2] = i_item.pos_z;

    always_comb begin
        for (int r = 0; r < MATRIX_SIZE; r++) begin
            for (int c = 0; c < MATRIX_SIZE - 1; c++) begin
                n_prod[r][c] = $signed(r_mat[r*MATRIX_SIZE+c]) * $signed(pos[c]);
            end
            // w column multiplies by one
            n_prod[r][MATRIX_SIZE-1] =
                PROD_W'(r_mat[r*MATRIX_SIZE+MATRIX_SIZE-1]) <<< FRACTION_BITS;
            n_pair[r][0] = (PROD_W+1)'(r_prod[r][0]) + (PROD_W+1)'(r_prod[r][1]);
            n_pair[r][1] = (PROD_W+1)'(r_prod[r][2]) + (PROD_W+1)'(r_prod[r][3]);
            row_sum[r]   = SUM_W'(r_pair[r][0]) + SUM_W'(r_pair[r][1]);
        end
    end

    // floor shift by the fraction width: plain bit select of two's complement
    assign o_clip.x = row_sum[0][SUM_W-2:FRACTION_BITS];
    assign o_clip.y = row_sum[1][SUM_W-2:FRACTION_BITS];
    assign o_clip.z = row_sum[2][SUM_W-2:FRACTION_BITS];
    assign o_clip.w = row_sum[3][SUM_W-2:FRACTION_BITS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_s_valid <= 1'b0;
            for (int i = 0; i < MAT_WORDS; i++) begin
                r_mat[i] <= '0;
            end
        end else begin
            if (accept && i_item.op == OP_COEF) begin
                r_mat[i_item.coef_index] <= i_item.coef_value;
            end
            if (fe_en) begin
                r_p_valid <= accept && i_item.op == OP_PROJECT;
                r_s_valid <= r_p_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fe_en) begin
            r_prod <= n_prod;
            r_pair <= n_pair;
        end
    end

endmodule

`default_nettype wire

@@ rtl/vpv_clip_queue.sv @@
// Two-entry queue of clip coordinates between front and back ends.
// Depends on vpv_pkg.
`default_nettype none

module vpv_clip_queue import vpv_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    output logic  o_full,
    input  t_clip i_clip,
    output logic  o_valid,
    output t_clip o_clip,
    input  logic  i_pop
);

    t_clip              r_data [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QPTR_W:0]    r_count;
    logic do_push;
    logic do_pop;

    assign o_full  = r_count == (QPTR_W+1)'(QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_clip  = r_data[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            r_count <= r_count + (QPTR_W+1)'(do_push) - (QPTR_W+1)'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_data[r_wr_ptr] <= i_clip;
        end
    end

endmodule

`default_nettype wire

@@ rtl/vpv_divider.sv @@
// Back end divide: four lanes of pipelined restoring division by clip w.
// Depends on vpv_pkg.
`default_nettype none

module vpv_divider import vpv_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_clip i_clip,
    output logic  o_ready,
    output logic  o_valid,
    output t_quot o_quot,
    input  logic  i_ready
);

    logic                  r_v   [QUOT_STEPS+1];
    logic [MAG_W-1:0]      r_den [QUOT_STEPS+1];
    logic                  r_wz  [QUOT_STEPS+1];
    logic [MAG_W-1:0]      r_rem [QUOT_STEPS+1][NUM_LANES];
    logic [QUOT_STEPS-1:0] r_low [QUOT_STEPS+1][NUM_LANES];
    logic [QUOT_STEPS-1:0] r_q   [QUOT_STEPS+1][NUM_LANES];
    logic                  r_neg [QUOT_STEPS+1][NUM_LANES];
    logic                  r_ovf [QUOT_STEPS+1][NUM_LANES];

    logic [MAG_W-1:0]      n_rem [QUOT_STEPS+1][NUM_LANES];
    logic [QUOT_STEPS-1:0] n_low [QUOT_STEPS+1][NUM_LANES];
    logic [QUOT_STEPS-1:0] n_q   [QUOT_STEPS+1][NUM_LANES];
    logic                  n_neg [NUM_LANES];
    logic                  n_ovf [NUM_LANES];

    logic  r_fin_v;
    t_quot r_fin;
    t_quot n_fin;

    logic                     div_en;
    logic signed [CLIP_W-1:0] num [NUM_LANES];
    logic [MAG_W-1:0]         num_mag [NUM_LANES];
    logic [MAG_W-1:0]         den_mag;
    logic [N_W-1:0]           dividend [NUM_LANES];
    logic [MAG_W:0]           shifted;
    logic                     ge;
    logic [QUOT_STEPS-1:0]    q_mag [NUM_LANES];
    logic [QV_W-1:0]          q_val [NUM_LANES];

    assign div_en  = !r_fin_v || i_ready;
    assign o_ready = div_en;
    assign o_valid = r_fin_v;
    assign o_quot  = r_fin;

    assign num[0] = i_clip.x;
    assign num[1] = i_clip.y;
    assign num[2] = i_clip.z;
    assign num[3] = CLIP_W'(ONE_Q);

    always_comb begin
        shifted = '0;
        ge      = 1'b0;
        den_mag = i_clip.w[CLIP_W-1] ? MAG_W'(~i_clip.w) + MAG_W'(1) : MAG_W'(i_clip.w);
        // entry stage: magnitudes, sign, top dividend bits, overflow test
        for (int l = 0; l < NUM_LANES; l++) begin
            num_mag[l]  = num[l][CLIP_W-1] ? MAG_W'(~num[l]) + MAG_W'(1) : MAG_W'(num[l]);
            dividend[l] = {num_mag[l], {FRACTION_BITS{1'b0}}};
            n_rem[0][l] = MAG_W'(dividend[l][N_W-1:QUOT_STEPS]);
            n_low[0][l] = dividend[l][QUOT_STEPS-1:0];
            n_q[0][l]   = '0;
            n_neg[l]    = num[l][CLIP_W-1] ^ i_clip.w[CLIP_W-1];
            n_ovf[l]    = n_rem[0][l] >= den_mag;
        end
        // one quotient bit per stage
        for (int s = 0; s < QUOT_STEPS; s++) begin
            for (int l = 0; l < NUM_LANES; l++) begin
                shifted = {r_rem[s][l], r_low[s][l][QUOT_STEPS-1]};
                ge      = shifted >= {1'b0, r_den[s]};
                n_rem[s+1][l] = ge ? MAG_W'(shifted - {1'b0, r_den[s]}) : MAG_W'(shifted);
                n_low[s+1][l] = r_low[s][l] << 1;
                n_q[s+1][l]   = {r_q[s][l][QUOT_STEPS-2:0], ge};
            end
        end
        // clamp and sign
        for (int l = 0; l < NUM_LANES; l++) begin
            q_mag[l] = (r_ovf[QUOT_STEPS][l] ||
                        r_q[QUOT_STEPS][l] > (QUOT_STEPS'(1) << QUOT_LIMIT_EXP))
                     ? (QUOT_STEPS'(1) << QUOT_LIMIT_EXP) : r_q[QUOT_STEPS][l];
            q_val[l] = r_neg[QUOT_STEPS][l] ? ~{1'b0, q_mag[l]} + QV_W'(1)
                                             : {1'b0, q_mag[l]};
        end
        n_fin.nx     = q_val[0];
        n_fin.ny     = q_val[1];
        n_fin.nz     = q_val[2];
        n_fin.rw     = q_val[3];
        n_fin.w_zero = r_wz[QUOT_STEPS];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_v <= 1'b0;
            for (int s = 0; s <= QUOT_STEPS; s++) begin
                r_v[s] <= 1'b0;
            end
        end else if (div_en) begin
            r_v[0]  <= i_valid;
            r_fin_v <= r_v[QUOT_STEPS];
            for (int s = 0; s < QUOT_STEPS; s++) begin
                r_v[s+1] <= r_v[s];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (div_en) begin
            r_den[0] <= den_mag;
            r_wz[0]  <= i_clip.w == '0;
            for (int l = 0; l < NUM_LANES; l++) begin
                r_neg[0][l] <= n_neg[l];
                r_ovf[0][l] <= n_ovf[l];
            end
            for (int s = 0; s < QUOT_STEPS; s++) begin
                r_den[s+1] <= r_den[s];
                r_wz[s+1]  <= r_wz[s];
                for (int l = 0; l < NUM_LANES; l++) begin
                    r_neg[s+1][l] <= r_neg[s][l];
                    r_ovf[s+1][l] <= r_ovf[s][l];
                end
            end
            r_rem <= n_rem;
            r_low <= n_low;
            r_q   <= n_q;
            r_fin <= n_fin;
        end
    end

endmodule

`default_nettype wire

@@ rtl/vpv_viewport.sv @@
// Back end tail: viewport scaling, saturation and the result queue.
// Depends on vpv_pkg and the assertion macro header.
`default_nettype none
`include "vertex_project_viewport_unit_assert.svh"

module vpv_viewport import vpv_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  t_quot             i_quot,
    output logic              o_ready,
    input  logic [SIZE_W-1:0] i_vp_width,
    input  logic [SIZE_W-1:0] i_vp_height,
    output logic              o_empty,
    input  logic              i_pop,
    output t_out_item         o_item
);

    logic                        r_m_v;
    logic signed [VP_PROD_W-1:0] r_px;
    logic signed [VP_PROD_W-1:0] r_py;
    logic signed [QV_W-1:0]      r_nz;
    logic signed [QV_W-1:0]      r_rw;
    logic                        r_wz;

    t_out_item          r_data [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QPTR_W:0]    r_count;

    logic signed [QV_W-1:0] sum_x;
    logic signed [QV_W-1:0] sum_y;
    t_out_item              res;
    logic of_full;
    logic vp_en;
    logic do_push;
    logic do_pop;

    assign of_full = r_count == (QPTR_W+1)'(QUEUE_DEPTH);
    assign vp_en   = !r_m_v || !of_full;
    assign o_ready = vp_en;
    assign do_push = r_m_v && !of_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_empty = r_count == '0;
    assign o_item  = r_data[r_rd_ptr];

    assign sum_x = i_quot.nx + QV_W'(ONE_Q);
    assign sum_y = QV_W'(ONE_Q) - i_quot.ny;

    always_comb begin
        res.screen_x = sat_data(r_px >>> 1);
        res.screen_y = sat_data(r_py >>> 1);
        res.depth_z  = sat_data(VP_PROD_W'(r_nz));
        res.recip_w  = sat_data(VP_PROD_W'(r_rw));
        res.w_zero   = r_wz;
        if (r_wz) begin
            res.screen_x = '0;
            res.screen_y = '0;
            res.depth_z  = '0;
            res.recip_w  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_v    <= 1'b0;
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (vp_en) begin
                r_m_v <= i_valid;
            end
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            r_count <= r_count + (QPTR_W+1)'(do_push) - (QPTR_W+1)'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (vp_en) begin
            r_px <= VP_PROD_W'(sum_x) * VP_PROD_W'($signed({1'b0, i_vp_width}));
            r_py <= VP_PROD_W'(sum_y) * VP_PROD_W'($signed({1'b0, i_vp_height}));
            r_nz <= i_quot.nz;
            r_rw <= i_quot.rw;
            r_wz <= i_quot.w_zero;
        end
        if (do_push) begin
            r_data[r_wr_ptr] <= res;
        end
    end

    `VPV_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, r_m_v && !vp_en, r_m_v && $stable(r_px))
    `VPV_ASSERT_IMPLIES(a_wz_zeroes, i_clk, i_rst_n, !o_empty && o_item.w_zero, o_item.screen_x == '0 && o_item.recip_w == '0)
    `VPV_ASSERT_IMPLIES(a_full_blocks, i_clk, i_rst_n, of_full && r_m_v, !o_ready)
    `VPV_ASSERT_NEXT(a_pop_moves, i_clk, i_rst_n, do_pop && !do_push, r_count != $past(r_count))

endmodule

`default_nettype wire

@@ rtl/vertex_project_viewport_unit.sv @@
// Top level of the vertex projection unit: config registers and the
// front/queue/divide/viewport chain. Depends on vpv_pkg and the vpv_* modules.
//
//  port group        dir   handshake        payload
//  input items       in    push / full      i_item  (t_in_item)
//  result items      out   empty / pop      o_item  (t_out_item)
//  config writes     in    i_cfg_we         i_cfg_idx, i_cfg_data
//
// One item per clock enters and leaves in steady state when nothing stalls.
// A projection item passes the product and pair-sum registers of the matrix
// multiply, the clip queue, the divider (one quotient bit per stage, 48 bits),
// the viewport multiply register, then the result queue.
// Coefficient items only update the matrix and give no result.
// Reset is synchronous, active low; it clears the matrix and all valids.
// A stalled result queue backs up the divider pipeline, then the clip queue,
// then the front end raises full.
`default_nettype none

module vertex_project_viewport_unit import vpv_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  t_in_item             i_item,
    output logic                 empty,
    input  logic                 pop,
    output t_out_item            o_item,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [SIZE_W-1:0]    i_cfg_data
);

    logic [SIZE_W-1:0] r_vp_width;
    logic [SIZE_W-1:0] r_vp_height;

    // front end -> clip queue
    logic  fe_valid;
    logic  q_full;
    t_clip fe_clip;
    // clip queue -> divider
    logic  q_valid;
    logic  div_ready;
    t_clip q_clip;
    // divider -> viewport
    logic  div_valid;
    logic  vp_ready;
    t_quot div_quot;

    // viewport size registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vp_width  <= WIDTH_RESET;
            r_vp_height <= HEIGHT_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_WIDTH:  r_vp_width  <= i_cfg_data;
                CFG_HEIGHT: r_vp_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // accepts items, writes coefficients, forms clip x/y/z/w
    vpv_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (full),
        .i_item  (i_item),
        .o_valid (fe_valid),
        .o_clip  (fe_clip),
        .i_ready (!q_full)
    );

    // decouples the front end from the divider stalls
    vpv_clip_queue u_clip_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fe_valid),
        .o_full  (q_full),
        .i_clip  (fe_clip),
        .o_valid (q_valid),
        .o_clip  (q_clip),
        .i_pop   (div_ready)
    );

    // perspective divide and reciprocal w
    vpv_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_clip  (q_clip),
        .o_ready (div_ready),
        .o_valid (div_valid),
        .o_quot  (div_quot),
        .i_ready (vp_ready)
    );

    // screen mapping, saturation, result queue
    vpv_viewport u_viewport (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (div_valid),
        .i_quot      (div_quot),
        .o_ready     (vp_ready),
        .i_vp_width  (r_vp_width),
        .i_vp_height (r_vp_height),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_item      (o_item)
    );

endmodule

`default_nettype wire
